FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds, consequent must hold in the same cycle.
`define ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");

// Antecedent holds, consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: rtl/ssiir_pkg.sv
// Shared widths, register indices and types for the saturating second-order IIR.
package ssiir_pkg;

  localparam int COEF_W     = 32;
  localparam int SAMPLE_W   = 16;
  localparam int SPEED_W    = 24;
  localparam int IN_LIM_W   = 15;
  localparam int OUT_LIM_W  = 23;
  localparam int COEF_FRAC  = COEF_W - 4;
  localparam int VOLT_ALIGN = 2;

  // accumulator: two speed products plus three aligned voltage products
  localparam int PROD_Y_W = COEF_W + SPEED_W + 1;
  localparam int PROD_V_W = COEF_W + SAMPLE_W + VOLT_ALIGN + 2;
  localparam int ACC_NEED = ((PROD_Y_W > PROD_V_W) ? PROD_Y_W : PROD_V_W) + 1;
  localparam int ACC_W    = (ACC_NEED > 64) ? 64 : ACC_NEED;
  localparam int Y_W      = ACC_W - COEF_FRAC;

  localparam int CMPV_W = ((SAMPLE_W > IN_LIM_W + 1) ? SAMPLE_W : IN_LIM_W + 1) + 1;
  localparam int CMPY_W = ((Y_W > OUT_LIM_W + 1) ? Y_W : OUT_LIM_W + 1) + 1;

  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (COEF_FRAC - 1);

  localparam int S_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((SPEED_W + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (COEF_W > OUT_LIM_W) ? COEF_W : OUT_LIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_OUT_1   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_OUT_2   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_IN_0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_IN_1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_IN_2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_LIMIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd6;

  localparam logic [IN_LIM_W-1:0]  IN_LIM_RST  = IN_LIM_W'(24576);   // 12 V
  localparam logic [OUT_LIM_W-1:0] OUT_LIM_RST = OUT_LIM_W'(1941504); // 237 rad/s

  typedef struct packed {
    logic [COEF_W-1:0]    coef_out_1;
    logic [COEF_W-1:0]    coef_out_2;
    logic [COEF_W-1:0]    coef_in_0;
    logic [COEF_W-1:0]    coef_in_1;
    logic [COEF_W-1:0]    coef_in_2;
    logic [IN_LIM_W-1:0]  input_limit;
    logic [OUT_LIM_W-1:0] output_limit;
  } cfg_t;

  typedef struct packed {
    logic [SPEED_W-1:0]  out_1;
    logic [SPEED_W-1:0]  out_2;
    logic [SAMPLE_W-1:0] in_1;
    logic [SAMPLE_W-1:0] in_2;
  } hist_t;

endpackage

FILE: rtl/ssiir_cfg.sv
// Configuration register file: coefficients and clamp limits.
module ssiir_cfg import ssiir_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [CFG_IDX_W-1:0]  index_i,
  input  logic [CFG_DATA_W-1:0] data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (valid_i) begin
      unique case (index_i)
        REG_COEF_OUT_1:   cfg_d.coef_out_1   = data_i[COEF_W-1:0];
        REG_COEF_OUT_2:   cfg_d.coef_out_2   = data_i[COEF_W-1:0];
        REG_COEF_IN_0:    cfg_d.coef_in_0    = data_i[COEF_W-1:0];
        REG_COEF_IN_1:    cfg_d.coef_in_1    = data_i[COEF_W-1:0];
        REG_COEF_IN_2:    cfg_d.coef_in_2    = data_i[COEF_W-1:0];
        REG_INPUT_LIMIT:  cfg_d.input_limit  = data_i[IN_LIM_W-1:0];
        REG_OUTPUT_LIMIT: cfg_d.output_limit = data_i[OUT_LIM_W-1:0];
        default:          cfg_d = cfg_q; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_out_1   <= '0;
      cfg_q.coef_out_2   <= '0;
      cfg_q.coef_in_0    <= '0;
      cfg_q.coef_in_1    <= '0;
      cfg_q.coef_in_2    <= '0;
      cfg_q.input_limit  <= IN_LIM_RST;
      cfg_q.output_limit <= OUT_LIM_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/ssiir_core.sv
// Filter datapath: input clamp, five products, round and output clamp.
module ssiir_core import ssiir_pkg::*; (
  input  cfg_t                cfg_i,
  input  hist_t               hist_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic [SAMPLE_W-1:0] clamped_o,
  output logic [SPEED_W-1:0]  speed_o
);

  logic signed [CMPV_W-1:0] v_ext, vlim, vlim_n, v_sat;
  logic signed [ACC_W-1:0]  p_y1, p_y2, p_v0, p_v1, p_v2;
  logic signed [ACC_W-1:0]  acc_y, acc_v, acc;
  logic        [ACC_W-1:0]  acc_rnd;
  logic signed [Y_W-1:0]    y;
  logic signed [CMPY_W-1:0] y_ext, ylim, ylim_n, y_sat;

  // input clamp
  assign v_ext  = CMPV_W'($signed(sample_i));
  assign vlim   = CMPV_W'($signed({1'b0, cfg_i.input_limit}));
  assign vlim_n = -vlim;

  always_comb begin
    priority if (v_ext >= vlim) v_sat = vlim;
    else if (v_ext <= vlim_n)   v_sat = vlim_n;
    else                        v_sat = v_ext;
  end

  assign clamped_o = v_sat[SAMPLE_W-1:0];

  // products, Q.41 for speed terms, Q.39 for voltage terms
  assign p_y1 = ACC_W'($signed(cfg_i.coef_out_1)) * ACC_W'($signed(hist_i.out_1));
  assign p_y2 = ACC_W'($signed(cfg_i.coef_out_2)) * ACC_W'($signed(hist_i.out_2));
  assign p_v0 = ACC_W'($signed(cfg_i.coef_in_0)) * ACC_W'(v_sat);
  assign p_v1 = ACC_W'($signed(cfg_i.coef_in_1)) * ACC_W'($signed(hist_i.in_1));
  assign p_v2 = ACC_W'($signed(cfg_i.coef_in_2)) * ACC_W'($signed(hist_i.in_2));

  assign acc_y   = p_y1 + p_y2;
  assign acc_v   = p_v0 + p_v1 + p_v2;
  assign acc     = acc_y + (acc_v <<< VOLT_ALIGN);
  assign acc_rnd = acc + ROUND_BIAS;

  // round half up to Q.13, floor shift
  assign y = $signed(acc_rnd[ACC_W-1:COEF_FRAC]);

  assign y_ext  = CMPY_W'(y);
  assign ylim   = CMPY_W'($signed({1'b0, cfg_i.output_limit}));
  assign ylim_n = -ylim;

  always_comb begin
    priority if (y_ext >= ylim) y_sat = ylim;
    else if (y_ext <= ylim_n)   y_sat = ylim_n;
    else                        y_sat = y_ext;
  end

  assign speed_o = y_sat[SPEED_W-1:0];

endmodule

FILE: rtl/saturating_second_order_iir.sv
// Top level of the saturating second-order IIR speed model.
// Streaming second-order direct-form-I filter that turns drive-voltage beats
// (Q5.11) into clamped speed beats (Q11.13), one result per input. The block
// takes one beat per clock sustained while the output accepts: a beat lands
// in the input register, and once the result register is free or draining,
// the whole recursion (input clamp, five multipliers, adder tree, rounding,
// output clamp) runs in one pass and writes the result register and the
// history registers together. Throughput is set by the feedback path through
// the multipliers and the adder back into the output history. The result
// register decouples the sides, so an input beat is taken while a finished
// result still waits; with both stages full, input ready follows output
// ready. Coefficients and limits are written through the config channel,
// which is always ready, and should only change while no beat is in flight.
//
// Config register map (cfg_index_i):
//   0 coef_out_1   Q4.28, weight of previous output
//   1 coef_out_2   Q4.28, weight of output two back
//   2 coef_in_0    Q4.28, weight of current clamped input
//   3 coef_in_1    Q4.28, weight of previous clamped input
//   4 coef_in_2    Q4.28, weight of clamped input two back
//   5 input_limit  Q5.11 magnitude, reset 12 V
//   6 output_limit Q11.13 magnitude, reset 237 rad/s
// Other indices are ignored; data bits above a register's width are dropped.
module saturating_second_order_iir import ssiir_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [15:0] voltage_sample
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata   // [23:0] speed_sample
);

  cfg_t                cfg;
  hist_t               hist_q, hist_d;
  logic                in_valid_q, in_valid_d;
  logic [SAMPLE_W-1:0] in_sample_q;
  logic                out_valid_q, out_valid_d;
  logic [SPEED_W-1:0]  out_speed_q;
  logic [SAMPLE_W-1:0] clamped;
  logic [SPEED_W-1:0]  speed;
  logic                s_beat, m_beat, advance;

  ssiir_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cfg_valid_i),
    .ready_o (cfg_ready_o),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  ssiir_core u_core (
    .cfg_i     (cfg),
    .hist_i    (hist_q),
    .sample_i  (in_sample_q),
    .clamped_o (clamped),
    .speed_o   (speed)
  );

  // the input stage moves on whenever the result register is free or drains
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_beat        = s_axis_tvalid && s_axis_tready;
  assign m_beat        = out_valid_q && m_axis_tready;

  assign in_valid_d  = s_beat || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_beat);

  // histories shift exactly when an item leaves the input stage
  always_comb begin
    hist_d = hist_q;
    if (advance) begin
      hist_d.out_2 = hist_q.out_1;
      hist_d.out_1 = speed;
      hist_d.in_2  = hist_q.in_1;
      hist_d.in_1  = clamped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hist_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      hist_q      <= hist_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      in_sample_q <= s_axis_tdata[SAMPLE_W-1:0];
    end
    if (advance) begin
      out_speed_q <= speed;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(out_speed_q);

endmodule

FILE: rtl/ssiir_checker.sv
// Port-level checker for the saturating second-order IIR, with its bind.
`include "assert_macros.svh"

module ssiir_checker import ssiir_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic [1:0] inflight_q, inflight_d;
  logic       s_beat, m_beat;

  assign s_beat = s_axis_tvalid && s_axis_tready;
  assign m_beat = m_axis_tvalid && m_axis_tready;

  always_comb begin
    inflight_d = inflight_q;
    if (s_beat && !m_beat) inflight_d = inflight_q + 2'd1;
    else if (m_beat && !s_beat) inflight_d = inflight_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // a stalled result beat keeps its value
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // two stages hold at most two items
  `ASSERT_IMPL(a_depth, 1'b1, inflight_q != 2'd3)
  // no result without an item taken in
  `ASSERT_IMPL(a_no_invent, m_axis_tvalid, inflight_q != 2'd0)
  // an empty block always takes input
  `ASSERT_IMPL(a_ready_empty, inflight_q == 2'd0, s_axis_tready)

endmodule

bind saturating_second_order_iir ssiir_checker u_ssiir_checker (.*);

FILE: sim/tb_top.sv
// Self-checking bench for the saturating second-order IIR: streamed voltages in, checked speeds out.
`timescale 1ns / 1ps

module tb_top;
  import ssiir_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // no register behind it

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;  // [15:0] voltage_sample
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;        // [23:0] speed_sample

  saturating_second_order_iir u_top (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // filter image: weights, limits and the two histories
  logic signed [COEF_W-1:0] w_y1 = '0, w_y2 = '0, w_v0 = '0, w_v1 = '0, w_v2 = '0;
  logic [IN_LIM_W-1:0]      lim_in  = IN_LIM_RST;
  logic [OUT_LIM_W-1:0]     lim_out = OUT_LIM_RST;
  longint                   y_prev1 = 0, y_prev2 = 0, v_prev1 = 0, v_prev2 = 0;

  logic [SAMPLE_W-1:0] volt_q[$];       // voltages waiting to be sent
  logic [SPEED_W-1:0]  speed_due_q[$];  // speeds owed by the block, oldest first

  logic volt_taken  = 1'b0;  // voltage beat went in at the last rising edge
  logic speed_taken = 1'b0;  // speed beat went out at the last rising edge
  logic src_steady  = 1'b0;  // sender offers back to back
  logic snk_steady  = 1'b0;  // receiver never stalls
  int   src_gap = 0, snk_gap = 0, hold_budget = 0;
  int   mismatch_cnt = 0, volts_sent = 0, speeds_seen = 0, reg_writes = 0, settings = 0;

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_COEF_OUT_1:   w_y1    = val[COEF_W-1:0];
      REG_COEF_OUT_2:   w_y2    = val[COEF_W-1:0];
      REG_COEF_IN_0:    w_v0    = val[COEF_W-1:0];
      REG_COEF_IN_1:    w_v1    = val[COEF_W-1:0];
      REG_COEF_IN_2:    w_v2    = val[COEF_W-1:0];
      REG_INPUT_LIMIT:  lim_in  = val[IN_LIM_W-1:0];
      REG_OUTPUT_LIMIT: lim_out = val[OUT_LIM_W-1:0];
      default: ;
    endcase
  endfunction

  // One filter step: clamp input, five products (voltage terms aligned Q.39 -> Q.41),
  // round half up to Q.13, clamp output, shift histories.
  function automatic logic [SPEED_W-1:0] next_speed(logic [SAMPLE_W-1:0] raw);
    longint v, acc, vsum, y, li, lo;
    li = longint'(lim_in);
    lo = longint'(lim_out);
    v  = longint'($signed(raw));
    if (v >= li) v = li;
    else if (v <= -li) v = -li;
    acc  = longint'(w_y1) * y_prev1 + longint'(w_y2) * y_prev2;
    vsum = longint'(w_v0) * v + longint'(w_v1) * v_prev1 + longint'(w_v2) * v_prev2;
    acc  = acc + (vsum <<< 2) + (64'sd1 <<< (COEF_FRAC - 1));
    y    = acc >>> COEF_FRAC;
    if (y >= lo) y = lo;
    else if (y <= -lo) y = -lo;
    y_prev2 = y_prev1;
    y_prev1 = y;
    v_prev2 = v_prev1;
    v_prev1 = v;
    return y[SPEED_W-1:0];
  endfunction

  function automatic void flag_error(string msg);
    if (mismatch_cnt < 10) $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endfunction

  // Voltage source: holds a beat until taken, then idles for a drawn number of cycles.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !volt_taken) begin
      // beat still on offer
    end else if (src_gap != 0) begin
      s_axis_tvalid <= 1'b0;
      src_gap       <= src_gap - 1;
    end else if (volt_q.size() != 0) begin
      s_axis_tdata  <= S_TDATA_W'(volt_q.pop_front());
      s_axis_tvalid <= 1'b1;
      src_gap       <= src_steady ? 0 : $urandom_range(0, 15);
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Speed sink: after each beat, stall for a drawn number of cycles; long hold when asked.
  always @(negedge clk_i) begin : sink_drive
    int stall;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_budget != 0) begin
      m_axis_tready <= 1'b0;
      hold_budget   <= hold_budget - 1;
    end else begin
      if (speed_taken) stall = snk_steady ? 0 : $urandom_range(0, 15);
      else stall = snk_gap;
      m_axis_tready <= (stall == 0);
      snk_gap       <= (stall == 0) ? 0 : stall - 1;
    end
  end

  // Monitor: predict on every accepted voltage, check every accepted speed.
  always @(posedge clk_i) begin : beat_monitor
    logic [SPEED_W-1:0] want;
    volt_taken  <= rst_ni && s_axis_tvalid && s_axis_tready;
    speed_taken <= rst_ni && m_axis_tvalid && m_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      speed_due_q.push_back(next_speed(s_axis_tdata[SAMPLE_W-1:0]));
      volts_sent++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      speeds_seen++;
      if (speed_due_q.size() == 0) begin
        flag_error($sformatf("speed beat %h with nothing outstanding",
                             m_axis_tdata[SPEED_W-1:0]));
      end else begin
        want = speed_due_q.pop_front();
        if (m_axis_tdata[SPEED_W-1:0] !== want)
          flag_error($sformatf("speed_sample expected %h got %h",
                               want, m_axis_tdata[SPEED_W-1:0]));
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Idle means: nothing queued or on offer and nothing owed, plus a wait for the pipe to settle.
  task automatic drain();
    while (volt_q.size() != 0 || s_axis_tvalid || speed_due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return CFG_DATA_W'(32'h7FFF_FFFF);
      1:       return CFG_DATA_W'(32'h8000_0000);
      2:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($signed($urandom) >>> $urandom_range(3, 9));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_limit(int w, logic [CFG_DATA_W-1:0] dflt);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return (CFG_DATA_W'(1) << w) - 1;
      2:       return dflt;
      default: return CFG_DATA_W'($urandom);  // upper bits should be dropped
    endcase
  endfunction

  // Mostly full-range voltages, with bursts around the clamp and near zero.
  function automatic logic [SAMPLE_W-1:0] pick_volt();
    int l;
    l = int'(lim_in);
    case ($urandom_range(0, 9))
      0:       return SAMPLE_W'(l - 1 + int'($urandom_range(0, 2)));
      1:       return SAMPLE_W'(-l - 1 + int'($urandom_range(0, 2)));
      2:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      3, 4:    return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic queue_volts(int n);
    @(posedge clk_i);
    repeat (n) volt_q.push_back(pick_volt());
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // reset weights are all zero: output stays at zero whatever comes in
    volt_q = {16'h7FFF, 16'h8000, 16'h0000};
    drain();

    // unity direct path, extreme weights on the delayed inputs, widest output clamp;
    // junk above the input limit width, and a write to an unused index
    write_reg(REG_COEF_OUT_1, '0);
    write_reg(REG_COEF_OUT_2, '0);
    write_reg(REG_COEF_IN_0, CFG_DATA_W'(32'h1000_0000));
    write_reg(REG_COEF_IN_1, CFG_DATA_W'(32'h8000_0000));
    write_reg(REG_COEF_IN_2, CFG_DATA_W'(32'h7FFF_FFFF));
    write_reg(REG_INPUT_LIMIT, CFG_DATA_W'(32'hFFFF_6000));
    write_reg(REG_OUTPUT_LIMIT, CFG_DATA_W'(32'hFF7F_FFFF));
    write_reg(REG_UNUSED, CFG_DATA_W'(32'hFFFF_FFFF));
    settings++;
    @(posedge clk_i);
    volt_q = {16'h7FFF, 16'h8000, 16'h6000, 16'h6001, 16'hA000, 16'h9FFF,
              16'h0001, 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA};
    drain();

    // zero limits force zero in and out
    write_reg(REG_INPUT_LIMIT, '0);
    write_reg(REG_OUTPUT_LIMIT, '0);
    settings++;
    @(posedge clk_i);
    volt_q = {16'h0064, 16'hFF9C, 16'h7FFF};
    drain();

    // widest input clamp, unit output clamp, extreme feedback weights
    write_reg(REG_INPUT_LIMIT, CFG_DATA_W'(16'h7FFF));
    write_reg(REG_OUTPUT_LIMIT, CFG_DATA_W'(1));
    write_reg(REG_COEF_OUT_1, CFG_DATA_W'(32'h7FFF_FFFF));
    write_reg(REG_COEF_OUT_2, CFG_DATA_W'(32'h8000_0000));
    settings++;
    @(posedge clk_i);
    volt_q = {16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'h7FFF};
    drain();
    write_reg(REG_OUTPUT_LIMIT, CFG_DATA_W'(23'h7F_FFFF));
    settings++;
    @(posedge clk_i);
    volt_q = {16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000};
    drain();

    // random part: one setting per phase, the first a stable low-pass near 1.8/-0.81
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        write_reg(REG_COEF_OUT_1, CFG_DATA_W'(32'h1CCC_CCCD));
        write_reg(REG_COEF_OUT_2, CFG_DATA_W'(32'hF30A_3D71));
        write_reg(REG_COEF_IN_0, CFG_DATA_W'(32'h00A3_D70A));
        write_reg(REG_COEF_IN_1, CFG_DATA_W'(32'h0147_AE14));
        write_reg(REG_COEF_IN_2, CFG_DATA_W'(32'h00A3_D70A));
        write_reg(REG_INPUT_LIMIT, CFG_DATA_W'(IN_LIM_RST));
        write_reg(REG_OUTPUT_LIMIT, CFG_DATA_W'(OUT_LIM_RST));
      end else begin
        write_reg(REG_COEF_OUT_1, pick_coef());
        write_reg(REG_COEF_OUT_2, pick_coef());
        write_reg(REG_COEF_IN_0, pick_coef());
        write_reg(REG_COEF_IN_1, pick_coef());
        write_reg(REG_COEF_IN_2, pick_coef());
        write_reg(REG_INPUT_LIMIT, pick_limit(IN_LIM_W, CFG_DATA_W'(IN_LIM_RST)));
        write_reg(REG_OUTPUT_LIMIT, pick_limit(OUT_LIM_W, CFG_DATA_W'(OUT_LIM_RST)));
        if (ph == 5) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
      end
      settings++;
      src_steady = (ph == 1 || ph == 3);
      snk_steady = (ph == 2);
      if (ph == 3) begin
        // sink holds off while the source keeps offering: block fills and back-pressures
        queue_volts(310);
        repeat (20) @(posedge clk_i);
        hold_budget = 200;
      end else if (ph == 4) begin
        // source pauses mid-phase until every speed is back
        queue_volts(150);
        drain();
        queue_volts(160);
      end else begin
        queue_volts(310);
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    $display("covered %0d voltage beats and %0d speed beats over %0d filter settings",
             volts_sent, speeds_seen, settings);
    $display("%0d register writes; %0d mismatches, %0d speeds never delivered",
             reg_writes, mismatch_cnt, speed_due_q.size());
    if (mismatch_cnt == 0 && speed_due_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("timeout with %0d speeds outstanding", speed_due_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
